// ===== hdl/pgt_pkg.sv =====
// Shared constants and stage numbering for the polar Gaussian transform pipeline.
package pgt_pkg;

    // Work formats and step counts of the iterative parts.
    localparam int WORK_FRAC  = 28;
    localparam int DIV_STEPS  = 63;
    localparam int NORM_STEPS = 6;
    localparam int LOG_ITERS  = 48;
    localparam int SQRT_STEPS = 32;

    // ln 2 in Q0.64, rounded.
    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

    // Stage numbers, counted from the input register as stage zero.
    localparam int STG_W       = 2;
    localparam int STG_DIV_END = STG_W + DIV_STEPS;
    localparam int STG_Y       = STG_W + NORM_STEPS + 2 * LOG_ITERS + 1;
    localparam int STG_L       = STG_Y + 2;
    localparam int C_DELAY     = STG_L - STG_DIV_END;
    localparam int STG_T       = STG_L + 2;
    localparam int STG_FMT     = STG_T + SQRT_STEPS + 1;

endpackage

// ===== hdl/polar_gaussian_transform_top.sv =====
// Fully pipelined Marsaglia polar Gaussian generator, uniform pair in, two samples out.
//
// Each input item is a pair of uniform Q0.32 fractions. The pair is mapped to
// x = 2u - 1, w = x1^2 + x2^2 is formed, and pairs with w >= 1 or w == 0 are
// dropped with no output. Kept pairs give two signed Q5.27 samples (with the
// default SAMPLE_FRAC_BITS), x1 first and x2 second with tlast set. The
// pipeline takes a new pair in every cycle while the output register is free;
// the output port carries one sample per cycle while m_tready is high, so each
// kept pair holds the output register, and with it the input, until both of its
// samples are taken, while a dropped pair passes as a bubble and never holds it.
// The whole pipeline advances together and holds on back-pressure.
module polar_gaussian_transform_top
    import pgt_pkg::*;
#(
    parameter int UNIFORM_BITS     = 32,
    parameter int SAMPLE_FRAC_BITS = 27
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] uniform_a, [63:32] uniform_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] gauss_sample
    output logic        m_tlast    // last_of_pair
);

    localparam int SH_R = (SAMPLE_FRAC_BITS <= WORK_FRAC) ? WORK_FRAC - SAMPLE_FRAC_BITS : 0;
    localparam int SH_L = (SAMPLE_FRAC_BITS > WORK_FRAC) ? SAMPLE_FRAC_BITS - WORK_FRAC : 0;

    logic adv;
    logic [STG_FMT:0] valid_reg, valid_next;
    logic [1:0] neg_reg [STG_FMT];

    logic [31:0] al     [2];
    logic [31:0] mag_next [2];
    logic [31:0] mag_reg  [2];
    logic [63:0] sq_reg   [2];
    logic [63:0] w_sum;
    logic        w_ok;
    logic [61:0] w_reg;
    logic [61:0] num_reg  [2];

    logic [62:0] drem_reg [DIV_STEPS][2];
    logic [62:0] dq_reg   [DIV_STEPS][2];
    logic [61:0] dden_reg [DIV_STEPS];

    logic [62:0] nv_reg [NORM_STEPS];
    logic [5:0]  ns_reg [NORM_STEPS];

    logic [63:0] lp00_reg [LOG_ITERS];
    logic [62:0] lp01_reg [LOG_ITERS];
    logic [61:0] lp11_reg [LOG_ITERS];
    logic [47:0] lfa_reg  [LOG_ITERS];
    logic [5:0]  lsa_reg  [LOG_ITERS];
    logic [62:0] lm_reg   [LOG_ITERS];
    logic [47:0] lf_reg   [LOG_ITERS];
    logic [5:0]  ls_reg   [LOG_ITERS];

    logic [53:0] y_reg;
    logic [53:0] yhh_reg, yhl_reg;
    logic [63:0] ylh_reg, yll_reg;
    logic [117:0] l_full;
    logic [62:0] l_reg;

    logic [62:0] cd_reg [C_DELAY][2];
    logic [61:0] thh_reg [2];
    logic [62:0] thl_reg [2];
    logic [62:0] tlh_reg [2];
    logic [63:0] tll_reg [2];
    logic [63:0] t_reg   [2];

    logic [63:0] sqt_reg [SQRT_STEPS][2];
    logic [63:0] sqr_reg [SQRT_STEPS][2];

    logic [31:0] fmt_reg [2];

    logic        ob_valid_reg;
    logic        ob_phase_reg;
    logic [31:0] ob_s_reg [2];

    // The pipeline moves when the output register is empty or its last sample leaves.
    assign adv      = !ob_valid_reg || (ob_phase_reg && m_tready);
    assign s_tready = adv;

    // Valid bits; a pair that fails the w test becomes a bubble.
    always_comb begin
        valid_next = {valid_reg[STG_FMT-1:0], s_tvalid};
        valid_next[STG_W] = valid_reg[STG_W-1] && w_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    // Sign bits of both coordinates travel alongside the data.
    always_ff @(posedge aclk) begin
        if (adv) begin
            neg_reg[0] <= {~al[1][31], ~al[0][31]};
            for (int k = 1; k < STG_FMT; k++) begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // Input alignment to Q0.32 and magnitude of u - 1/2, which is half of x.
    for (genvar l = 0; l < 2; l++) begin : g_in
        logic [31:0] raw;
        assign raw = s_tdata[32*l +: 32];
        if (UNIFORM_BITS >= 32) begin : g_wide
            assign al[l] = raw >> (UNIFORM_BITS - 32);
        end else begin : g_narrow
            assign al[l] = (raw & ((32'd1 << UNIFORM_BITS) - 32'd1)) << (32 - UNIFORM_BITS);
        end
        assign mag_next[l] = al[l][31] ? {1'b0, al[l][30:0]} : (32'h8000_0000 - al[l]);

        always_ff @(posedge aclk) begin
            if (adv) begin
                mag_reg[l] <= mag_next[l];
                sq_reg[l]  <= 64'(mag_reg[l]) * 64'(mag_reg[l]);
                num_reg[l] <= sq_reg[l][61:0];
            end
        end
    end

    // Sum of squares and the rejection test.
    assign w_sum = sq_reg[0] + sq_reg[1];
    assign w_ok  = (w_sum != 64'd0) && (w_sum < 64'h4000_0000_0000_0000);

    always_ff @(posedge aclk) begin
        if (adv) begin
            w_reg <= w_sum[61:0];
        end
    end

    // Restoring division x^2 / w, one quotient bit per stage, both lanes.
    for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
        logic [61:0] den;
        if (d == 0) begin : g_first
            assign den = w_reg;
        end else begin : g_next
            assign den = dden_reg[d-1];
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dden_reg[d] <= den;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [62:0] rem_in, q_in, rem_next, q_next;
            logic [61:0] r;
            logic        ge;
            if (d == 0) begin : g_first
                assign rem_in = {1'b0, num_reg[l]};
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = drem_reg[d-1][l];
                assign q_in   = dq_reg[d-1][l];
            end
            assign ge       = rem_in >= {1'b0, den};
            assign r        = ge ? 62'(rem_in - {1'b0, den}) : rem_in[61:0];
            assign rem_next = {r, 1'b0};
            assign q_next   = {q_in[61:0], ge};

            always_ff @(posedge aclk) begin
                if (adv) begin
                    drem_reg[d][l] <= rem_next;
                    dq_reg[d][l]   <= q_next;
                end
            end
        end
    end

    // Normalization of w to [1,2) by a binary search over the leading zeros.
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int K = 32 >> j;
        logic [62:0] v_in, v_next;
        logic [5:0]  s_in, s_next;
        logic        zero;
        if (j == 0) begin : g_first
            assign v_in = {1'b0, w_reg};
            assign s_in = '0;
        end else begin : g_next
            assign v_in = nv_reg[j-1];
            assign s_in = ns_reg[j-1];
        end
        assign zero   = (v_in[62 -: K] == '0);
        assign v_next = zero ? (v_in << K) : v_in;
        assign s_next = zero ? (s_in + 6'(K)) : s_in;

        always_ff @(posedge aclk) begin
            if (adv) begin
                nv_reg[j] <= v_next;
                ns_reg[j] <= s_next;
            end
        end
    end

    // log2 by repeated squaring: partial products in one stage, sum in the next.
    for (genvar j = 0; j < LOG_ITERS; j++) begin : g_log
        logic [62:0]  m_in;
        logic [47:0]  f_in;
        logic [5:0]   s_in;
        logic [125:0] full;
        logic [63:0]  sq;
        logic [62:0]  m_next;
        if (j == 0) begin : g_first
            assign m_in = nv_reg[NORM_STEPS-1];
            assign f_in = '0;
            assign s_in = ns_reg[NORM_STEPS-1];
        end else begin : g_next
            assign m_in = lm_reg[j-1];
            assign f_in = lf_reg[j-1];
            assign s_in = ls_reg[j-1];
        end
        assign full   = {lp11_reg[j], 64'd0} + (126'(lp01_reg[j]) << 33) + 126'(lp00_reg[j]);
        assign sq     = full[125:62];
        assign m_next = sq[63] ? sq[63:1] : sq[62:0];

        always_ff @(posedge aclk) begin
            if (adv) begin
                lp00_reg[j] <= 64'(m_in[31:0]) * 64'(m_in[31:0]);
                lp01_reg[j] <= 63'(m_in[31:0]) * 63'(m_in[62:32]);
                lp11_reg[j] <= 62'(m_in[62:32]) * 62'(m_in[62:32]);
                lfa_reg[j]  <= f_in;
                lsa_reg[j]  <= s_in;
                lm_reg[j]   <= m_next;
                lf_reg[j]   <= {lfa_reg[j][46:0], sq[63]};
                ls_reg[j]   <= lsa_reg[j];
            end
        end
    end

    // -log2 w, then times 2 ln 2 into Q7.56.
    assign l_full = (118'(yhh_reg) << 64) + ((118'(yhl_reg) + 118'(ylh_reg)) << 32)
                  + 118'(yll_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_reg   <= (54'(ls_reg[LOG_ITERS-1]) << 48) - 54'(lf_reg[LOG_ITERS-1]);
            yhh_reg <= 54'(y_reg[53:32]) * 54'(LN2_Q64[63:32]);
            yhl_reg <= 54'(y_reg[53:32]) * 54'(LN2_Q64[31:0]);
            ylh_reg <= 64'(y_reg[31:0]) * 64'(LN2_Q64[63:32]);
            yll_reg <= 64'(y_reg[31:0]) * 64'(LN2_Q64[31:0]);
            l_reg   <= l_full[117:55];
        end
    end

    // Quotients wait for the logarithm, then t = c * L and its square root.
    for (genvar l = 0; l < 2; l++) begin : g_out
        logic [125:0] t_full;
        logic [63:0]  s_r;
        logic [31:0]  s_out;

        always_ff @(posedge aclk) begin
            if (adv) begin
                cd_reg[0][l] <= dq_reg[DIV_STEPS-1][l];
                for (int i = 1; i < C_DELAY; i++) begin
                    cd_reg[i][l] <= cd_reg[i-1][l];
                end
            end
        end

        assign t_full = {thh_reg[l], 64'd0} + ((126'(thl_reg[l]) + 126'(tlh_reg[l])) << 32)
                      + 126'(tll_reg[l]);

        always_ff @(posedge aclk) begin
            if (adv) begin
                thh_reg[l] <= 62'(cd_reg[C_DELAY-1][l][62:32]) * 62'(l_reg[62:32]);
                thl_reg[l] <= 63'(cd_reg[C_DELAY-1][l][62:32]) * 63'(l_reg[31:0]);
                tlh_reg[l] <= 63'(cd_reg[C_DELAY-1][l][31:0]) * 63'(l_reg[62:32]);
                tll_reg[l] <= 64'(cd_reg[C_DELAY-1][l][31:0]) * 64'(l_reg[31:0]);
                t_reg[l]   <= t_full[125:62];
            end
        end

        // Bitwise integer square root, one result bit per stage.
        for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
            logic [63:0] t_in, r_in, trial;
            logic        ge;
            if (i == 0) begin : g_first
                assign t_in = t_reg[l];
                assign r_in = '0;
            end else begin : g_next
                assign t_in = sqt_reg[i-1][l];
                assign r_in = sqr_reg[i-1][l];
            end
            assign trial = r_in + BIT;
            assign ge    = t_in >= trial;

            always_ff @(posedge aclk) begin
                if (adv) begin
                    sqt_reg[i][l] <= ge ? (t_in - trial) : t_in;
                    sqr_reg[i][l] <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
                end
            end
        end

        // Scale to the output format, apply the sign and saturate.
        if (SH_R > 0) begin : g_round
            assign s_r = (sqr_reg[SQRT_STEPS-1][l] + (64'd1 << (SH_R - 1))) >> SH_R;
        end else begin : g_shift
            assign s_r = sqr_reg[SQRT_STEPS-1][l] << SH_L;
        end

        always_comb begin
            if (neg_reg[STG_FMT-1][l]) begin
                s_out = (s_r > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - s_r[31:0]);
            end else begin
                s_out = (s_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : s_r[31:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                fmt_reg[l] <= s_out;
            end
        end
    end

    // Output register: holds one pair and hands out its two samples in order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_valid_reg <= 1'b0;
            ob_phase_reg <= 1'b0;
        end else if (adv) begin
            ob_valid_reg <= valid_reg[STG_FMT];
            ob_phase_reg <= 1'b0;
        end else if (m_tready) begin
            ob_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ob_s_reg[0] <= fmt_reg[0];
            ob_s_reg[1] <= fmt_reg[1];
        end
    end

    assign m_tvalid = ob_valid_reg;
    assign m_tdata  = ob_phase_reg ? ob_s_reg[1] : ob_s_reg[0];
    assign m_tlast  = ob_phase_reg;

endmodule

// ===== hdl/pgt_checker.sv =====
// Port-level checks for the polar Gaussian transform and their binding to the top level.
module pgt_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast
);

    // A sample that is offered stays offered until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // Once the first sample of a pair is taken, the second follows at once.
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("second sample of a pair missing");

    // No new input item is taken while the first sample of a pair waits.
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input item taken while output pair pending");

    // An empty output register never holds back the input.
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output item present after reset");

endmodule

bind polar_gaussian_transform_top pgt_checker u_pgt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);
